[rtl/mvsc_pkg.sv]
// shared types and constants for the memory map with video setup capture
`timescale 1ns / 1ps

package mvsc_pkg;

  localparam int unsigned MemDepth = 65536;
  localparam int unsigned MemAw    = $clog2(MemDepth);
  localparam logic [MemAw-1:0] MemLast = MemAw'(MemDepth - 1);

  localparam logic [15:0] RomBase       = 16'hF800;
  localparam logic [15:0] RegMask       = 16'hEFFF;
  localparam logic [15:0] AddrIndicator = 16'h8003;
  localparam logic [15:0] AddrKbdPort   = 16'h8001;
  localparam logic [15:0] AddrCrtCmd    = 16'hC001;
  localparam logic [15:0] AddrCrtData   = 16'hC000;
  localparam logic [15:0] AddrDmaMode   = 16'hE008;
  localparam logic [15:0] AddrDmaBase   = 16'hE004;
  localparam logic [15:0] AddrDmaSize   = 16'hE005;

  localparam logic [7:0] CmdCursor   = 8'h80;
  localparam logic [7:0] CmdFormat   = 8'h00;
  localparam logic [7:0] CmdDmaMode  = 8'h80;
  localparam logic [7:0] CmdDmaStart = 8'hA4;
  localparam logic [7:0] PortIdle    = 8'hFF;

  typedef enum logic [1:0] {
    ACT_READ      = 2'd0,
    ACT_WRITE     = 2'd1,
    ACT_RAW_READ  = 2'd2,
    ACT_RAW_WRITE = 2'd3
  } action_e;

  typedef struct packed {
    logic [7:0]  screen_cols;
    logic [6:0]  screen_rows;
    logic [15:0] video_base;
    logic [14:0] video_size;
    logic [8:0]  cursor_col;
    logic [8:0]  cursor_row;
    logic        tape_output;
    logic        rus_lat;
  } video_status_t;

endpackage

[rtl/mvsc_decode.sv]
// register decode for crt controller, dma controller and indicator writes
`timescale 1ns / 1ps

module mvsc_decode (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [15:0]            addr_i,
  input  logic [7:0]             data_i,
  output mvsc_pkg::video_status_t status_o
);
  import mvsc_pkg::*;

  typedef enum logic [1:0] {
    CUR_IDLE,
    CUR_COL,
    CUR_ROW
  } cur_seq_e;

  typedef enum logic [1:0] {
    FMT_IDLE,
    FMT_COLS,
    FMT_ROWS
  } fmt_seq_e;

  typedef enum logic [2:0] {
    DMA_IDLE,
    DMA_BASE_LO,
    DMA_BASE_HI,
    DMA_SIZE_LO,
    DMA_SIZE_HI
  } dma_seq_e;

  cur_seq_e      cur_seq_q;
  fmt_seq_e      fmt_seq_q;
  dma_seq_e      dma_seq_q;
  logic [8:0]    cur_col_buf_q;
  logic [7:0]    cols_buf_q;
  logic [6:0]    rows_buf_q;
  logic [15:0]   base_buf_q;
  logic [14:0]   size_buf_q;
  video_status_t status_q;

  logic [15:0] reg_addr;
  logic [8:0]  cur_val;
  logic [7:0]  cols_val;
  logic [6:0]  rows_val;
  logic [15:0] base_hi_val;
  logic [13:0] size_raw;
  logic [14:0] size_val;

  always_comb begin
    reg_addr    = addr_i & RegMask;
    cur_val     = {1'b0, data_i} + 9'd1;
    cols_val    = {1'b0, data_i[6:0]} + 8'd1;
    rows_val    = {1'b0, data_i[5:0]} + 7'd1;
    base_hi_val = base_buf_q | {data_i, 8'h00};
    size_raw    = size_buf_q[13:0] | {data_i[5:0], 8'h00};
    size_val    = {1'b0, size_raw} + 15'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_seq_q     <= CUR_IDLE;
      fmt_seq_q     <= FMT_IDLE;
      dma_seq_q     <= DMA_IDLE;
      cur_col_buf_q <= '0;
      cols_buf_q    <= '0;
      rows_buf_q    <= '0;
      base_buf_q    <= '0;
      size_buf_q    <= '0;
      status_q      <= '0;
    end else if (wr_en_i) begin
      priority if (reg_addr == AddrIndicator) begin
        status_q.rus_lat <= data_i[0];
      end else if (reg_addr == AddrCrtCmd && data_i == CmdCursor) begin
        cur_seq_q <= CUR_COL;
      end else if (reg_addr == AddrCrtData && cur_seq_q == CUR_COL) begin
        cur_col_buf_q <= cur_val;
        cur_seq_q     <= CUR_ROW;
      end else if (reg_addr == AddrCrtData && cur_seq_q == CUR_ROW) begin
        status_q.cursor_col <= cur_col_buf_q;
        status_q.cursor_row <= cur_val;
        cur_seq_q           <= CUR_IDLE;
      end else if (reg_addr == AddrCrtCmd && data_i == CmdFormat) begin
        fmt_seq_q <= FMT_COLS;
      end else if (reg_addr == AddrCrtData && fmt_seq_q == FMT_COLS) begin
        cols_buf_q <= cols_val;
        fmt_seq_q  <= FMT_ROWS;
      end else if (reg_addr == AddrCrtData && fmt_seq_q == FMT_ROWS) begin
        rows_buf_q <= rows_val;
        fmt_seq_q  <= FMT_IDLE;
      end else if (reg_addr == AddrDmaMode && data_i == CmdDmaMode) begin
        dma_seq_q            <= DMA_BASE_LO;
        status_q.tape_output <= 1'b1;
      end else if (reg_addr == AddrDmaBase && dma_seq_q == DMA_BASE_LO) begin
        base_buf_q <= {8'h00, data_i};
        dma_seq_q  <= DMA_BASE_HI;
      end else if (reg_addr == AddrDmaBase && dma_seq_q == DMA_BASE_HI) begin
        base_buf_q <= base_hi_val;
        dma_seq_q  <= DMA_SIZE_LO;
      end else if (reg_addr == AddrDmaSize && dma_seq_q == DMA_SIZE_LO) begin
        size_buf_q <= {7'h00, data_i};
        dma_seq_q  <= DMA_SIZE_HI;
      end else if (reg_addr == AddrDmaSize && dma_seq_q == DMA_SIZE_HI) begin
        size_buf_q <= size_val;
        dma_seq_q  <= DMA_IDLE;
      end else if (reg_addr == AddrDmaMode && data_i == CmdDmaStart) begin
        if (cols_buf_q != '0 && rows_buf_q != '0) begin
          status_q.screen_cols <= cols_buf_q;
          status_q.screen_rows <= rows_buf_q;
          status_q.video_base  <= base_buf_q;
          status_q.video_size  <= size_buf_q;
        end
        status_q.tape_output <= 1'b0;
      end else begin
        // plain memory location, nothing to track
      end
    end
  end

  assign status_o = status_q;

endmodule

[rtl/memory_map_video_setup_capture.sv]
// top level: 64k byte memory map with crt and dma setup capture
`timescale 1ns / 1ps

// One bus access is taken per clock while busy_o is low. The result of an
// access appears in the cycle after its transfer, for exactly one cycle with
// done_o high, and must be taken then: the receiver cannot stall it. Accesses
// may follow each other in consecutive cycles; the single-port byte memory is
// written and read in the transfer cycle and its registered read data forms
// the result of memory reads. After reset, busy_o stays high while the
// memory is swept to zero one byte per cycle.
module memory_map_video_setup_capture (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic [7:0]  screen_cols_o,
  output logic [6:0]  screen_rows_o,
  output logic [15:0] video_base_o,
  output logic [14:0] video_size_o,
  output logic [8:0]  cursor_col_o,
  output logic [8:0]  cursor_row_o,
  output logic        tape_output_o,
  output logic        rus_lat_o
);
  import mvsc_pkg::*;

  typedef enum logic [1:0] {
    RD_ZERO,
    RD_PORT,
    RD_MEM
  } rd_sel_e;

  logic [7:0] mem_q [MemDepth];
  logic [7:0] mem_rdata_q;

  logic             clr_q;
  logic [MemAw-1:0] clr_idx_q;
  logic             done_q;
  rd_sel_e          rd_sel_q;
  rd_sel_e          rd_sel_d;

  logic             accept;
  logic             norm_write;
  logic             mem_we;
  logic [MemAw-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  video_status_t    status;

  always_comb begin
    accept     = start_i && !clr_q;
    norm_write = accept && action_i == ACT_WRITE && address_i < RomBase;
    mem_we     = clr_q || norm_write || (accept && action_i == ACT_RAW_WRITE);
    mem_waddr  = clr_q ? clr_idx_q : address_i;
    mem_wdata  = clr_q ? 8'h00 : write_data_i;
    unique case (action_i)
      ACT_READ: begin
        if (address_i == AddrKbdPort || address_i == AddrCrtCmd) begin
          rd_sel_d = RD_PORT;
        end else begin
          rd_sel_d = RD_MEM;
        end
      end
      ACT_RAW_READ: rd_sel_d = RD_MEM;
      default:      rd_sel_d = RD_ZERO;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem_q[mem_waddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
      done_q    <= 1'b0;
      rd_sel_q  <= RD_ZERO;
    end else begin
      if (clr_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == MemLast) begin
          clr_q <= 1'b0;
        end
      end
      done_q <= accept;
      if (accept) begin
        rd_sel_q <= rd_sel_d;
      end
    end
  end

  mvsc_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (norm_write),
    .addr_i   (address_i),
    .data_i   (write_data_i),
    .status_o (status)
  );

  always_comb begin
    unique case (rd_sel_q)
      RD_PORT: read_data_o = PortIdle;
      RD_MEM:  read_data_o = mem_rdata_q;
      default: read_data_o = 8'h00;
    endcase
  end

  assign busy_o        = clr_q;
  assign done_o        = done_q;
  assign screen_cols_o = status.screen_cols;
  assign screen_rows_o = status.screen_rows;
  assign video_base_o  = status.video_base;
  assign video_size_o  = status.video_size;
  assign cursor_col_o  = status.cursor_col;
  assign cursor_row_o  = status.cursor_row;
  assign tape_output_o = status.tape_output;
  assign rus_lat_o     = status.rus_lat;

`ifndef SYNTHESIS
  a_done_follows_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("result strobe without a preceding transfer");

  a_clear_runs_to_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q && clr_idx_q != MemLast |=> clr_q)
    else $error("memory clear ended early");

  a_clear_ends_at_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> $past(clr_idx_q) == MemLast)
    else $error("memory clear ended at wrong entry");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy rose again after memory clear");
`endif

endmodule

[dv/memory_map_video_setup_capture_test.sv]
// self-checking testbench for the memory map with crt and dma setup capture
`timescale 1ns / 1ps

module memory_map_video_setup_capture_test;
  import mvsc_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned RandomItems = 1150;
  localparam logic [15:0] RegAddrs [7] = '{AddrIndicator, AddrKbdPort, AddrCrtCmd,
                                           AddrCrtData, AddrDmaMode, AddrDmaBase,
                                           AddrDmaSize};

  typedef struct {
    logic [7:0]    read_data;
    video_status_t status;
  } bus_result_t;

  class video_map_scoreboard;
    bit [7:0]      mem_img [MemDepth];
    bit [1:0]      cursor_step;
    bit [1:0]      format_step;
    bit [2:0]      dma_step;
    bit [8:0]      col_buf;
    bit [7:0]      cols_buf;
    bit [6:0]      rows_buf;
    bit [15:0]     base_buf;
    bit [14:0]     size_buf;
    video_status_t shown = '0;
    bus_result_t   awaited_results [$];
    int unsigned   mismatches;

    function void decode_register_write(logic [15:0] addr, logic [7:0] data);
      logic [15:0] reg_addr;
      reg_addr = addr & RegMask;
      if (reg_addr == AddrIndicator) begin
        shown.rus_lat = data[0];
      end else if (reg_addr == AddrCrtCmd && data == CmdCursor) begin
        cursor_step = 2'd1;
      end else if (reg_addr == AddrCrtData && cursor_step == 2'd1) begin
        col_buf = 9'(data) + 9'd1;
        cursor_step = 2'd2;
      end else if (reg_addr == AddrCrtData && cursor_step == 2'd2) begin
        shown.cursor_col = col_buf;
        shown.cursor_row = 9'(data) + 9'd1;
        cursor_step = 2'd0;
      end else if (reg_addr == AddrCrtCmd && data == CmdFormat) begin
        format_step = 2'd1;
      end else if (reg_addr == AddrCrtData && format_step == 2'd1) begin
        cols_buf = {1'b0, data[6:0]} + 8'd1;
        format_step = 2'd2;
      end else if (reg_addr == AddrCrtData && format_step == 2'd2) begin
        rows_buf = {1'b0, data[5:0]} + 7'd1;
        format_step = 2'd0;
      end else if (reg_addr == AddrDmaMode && data == CmdDmaMode) begin
        dma_step = 3'd1;
        shown.tape_output = 1'b1;
      end else if (reg_addr == AddrDmaBase && dma_step == 3'd1) begin
        base_buf = {8'h00, data};
        dma_step = 3'd2;
      end else if (reg_addr == AddrDmaBase && dma_step == 3'd2) begin
        base_buf[15:8] = data;
        dma_step = 3'd3;
      end else if (reg_addr == AddrDmaSize && dma_step == 3'd3) begin
        size_buf = {7'd0, data};
        dma_step = 3'd4;
      end else if (reg_addr == AddrDmaSize && dma_step == 3'd4) begin
        size_buf = {1'b0, data[5:0], size_buf[7:0]} + 15'd1;
        dma_step = 3'd0;
      end else if (reg_addr == AddrDmaMode && data == CmdDmaStart) begin
        if (cols_buf != 8'd0 && rows_buf != 7'd0) begin
          shown.screen_cols = cols_buf;
          shown.screen_rows = rows_buf;
          shown.video_base  = base_buf;
          shown.video_size  = size_buf;
        end
        shown.tape_output = 1'b0;
      end
    endfunction

    function void record_access(action_e act, logic [15:0] addr, logic [7:0] data);
      bus_result_t r;
      r.read_data = 8'h00;
      case (act)
        ACT_READ: begin
          if (addr == AddrKbdPort || addr == AddrCrtCmd) r.read_data = PortIdle;
          else r.read_data = mem_img[addr];
        end
        ACT_WRITE: begin
          if (addr < RomBase) begin
            mem_img[addr] = data;
            decode_register_write(addr, data);
          end
        end
        ACT_RAW_READ: r.read_data = mem_img[addr];
        default: mem_img[addr] = data;
      endcase
      r.status = shown;
      awaited_results.push_back(r);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [7:0] rd, video_status_t got);
      bus_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no access outstanding");
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      check_field("read_data", 16'(want.read_data), 16'(rd));
      check_field("screen_cols", 16'(want.status.screen_cols), 16'(got.screen_cols));
      check_field("screen_rows", 16'(want.status.screen_rows), 16'(got.screen_rows));
      check_field("video_base", want.status.video_base, got.video_base);
      check_field("video_size", 16'(want.status.video_size), 16'(got.video_size));
      check_field("cursor_col", 16'(want.status.cursor_col), 16'(got.cursor_col));
      check_field("cursor_row", 16'(want.status.cursor_row), 16'(got.cursor_row));
      check_field("tape_output", 16'(want.status.tape_output), 16'(got.tape_output));
      check_field("rus_lat", 16'(want.status.rus_lat), 16'(got.rus_lat));
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  logic          busy_o;
  logic [1:0]    action_i;
  logic [15:0]   address_i;
  logic [7:0]    write_data_i;
  logic          done_o;
  logic [7:0]    read_data_o;
  logic [7:0]    screen_cols_o;
  logic [6:0]    screen_rows_o;
  logic [15:0]   video_base_o;
  logic [14:0]   video_size_o;
  logic [8:0]    cursor_col_o;
  logic [8:0]    cursor_row_o;
  logic          tape_output_o;
  logic          rus_lat_o;
  video_status_t seen_status;

  video_map_scoreboard sb;
  int unsigned         idle_pct;
  int unsigned         sent;
  int unsigned         cycle_count;

  memory_map_video_setup_capture dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .done_o        (done_o),
    .read_data_o   (read_data_o),
    .screen_cols_o (screen_cols_o),
    .screen_rows_o (screen_rows_o),
    .video_base_o  (video_base_o),
    .video_size_o  (video_size_o),
    .cursor_col_o  (cursor_col_o),
    .cursor_row_o  (cursor_row_o),
    .tape_output_o (tape_output_o),
    .rus_lat_o     (rus_lat_o)
  );

  assign seen_status = {screen_cols_o, screen_rows_o, video_base_o, video_size_o,
                        cursor_col_o, cursor_row_o, tape_output_o, rus_lat_o};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(read_data_o, seen_status);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("memory_map_video_setup_capture: mismatch");
    $finish;
  end

  task automatic send_access(input action_e act, input logic [15:0] addr,
                             input logic [7:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    action_i     <= act;
    address_i    <= addr;
    write_data_i <= data;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.record_access(act, addr, data);
    sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] mirror_addr(logic [15:0] a);
    return a | {3'b000, 1'($urandom_range(0, 1)), 12'h000};
  endfunction

  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'h0100 + 16'($urandom_range(0, 15));
      2: return mirror_addr(RegAddrs[$urandom_range(0, 6)]);
      default: return 16'hF7F0 + 16'($urandom_range(0, 31));
    endcase
  endfunction

  task automatic run_directed();
    send_access(ACT_READ, 16'h0000, 8'h00);
    send_access(ACT_WRITE, RomBase, 8'h5A);
    send_access(ACT_READ, RomBase, 8'h00);
    send_access(ACT_RAW_WRITE, 16'hFFFF, 8'hA5);
    send_access(ACT_RAW_READ, 16'hFFFF, 8'hFF);
    send_access(ACT_READ, AddrKbdPort, 8'h00);
    send_access(ACT_WRITE, AddrDmaMode, CmdDmaStart);
    send_access(ACT_WRITE, AddrIndicator, 8'hFF);
    send_access(ACT_WRITE, AddrCrtData, 8'h33);
    send_access(ACT_WRITE, AddrCrtCmd | 16'h1000, CmdCursor);
    send_access(ACT_WRITE, AddrCrtData, 8'hFF);
    send_access(ACT_WRITE, AddrCrtData | 16'h1000, 8'h00);
    send_access(ACT_WRITE, AddrCrtCmd, CmdFormat);
    send_access(ACT_WRITE, AddrCrtData, 8'hFF);
    send_access(ACT_WRITE, AddrCrtData | 16'h1000, 8'hFF);
    send_access(ACT_WRITE, AddrDmaMode, CmdDmaMode);
    send_access(ACT_WRITE, AddrDmaBase, 8'hFF);
    send_access(ACT_WRITE, AddrDmaBase | 16'h1000, 8'hFF);
    send_access(ACT_WRITE, AddrDmaSize, 8'hFF);
    send_access(ACT_WRITE, AddrDmaSize | 16'h1000, 8'hFF);
    send_access(ACT_WRITE, AddrDmaMode | 16'h1000, CmdDmaStart);
    // commit right after the low size byte
    send_access(ACT_WRITE, AddrDmaMode, CmdDmaMode);
    send_access(ACT_WRITE, AddrDmaBase, 8'h00);
    send_access(ACT_WRITE, AddrDmaBase, 8'h00);
    send_access(ACT_WRITE, AddrDmaSize, 8'h7E);
    send_access(ACT_WRITE, AddrDmaMode, CmdDmaStart);
    send_access(ACT_READ, AddrCrtCmd, 8'h00);
    send_access(ACT_WRITE, AddrIndicator | 16'h1000, 8'h00);
  endtask

  task automatic random_sequence();
    logic [7:0] reg_data;
    case ($urandom_range(0, 11))
      0, 1: begin
        send_access(ACT_WRITE, mirror_addr(AddrCrtCmd), CmdCursor);
        send_access(ACT_WRITE, mirror_addr(AddrCrtData), 8'($urandom));
        if ($urandom_range(0, 7) != 0)
          send_access(ACT_WRITE, mirror_addr(AddrCrtData), 8'($urandom));
      end
      2, 3: begin
        send_access(ACT_WRITE, mirror_addr(AddrCrtCmd), CmdFormat);
        send_access(ACT_WRITE, mirror_addr(AddrCrtData), 8'($urandom));
        if ($urandom_range(0, 7) != 0)
          send_access(ACT_WRITE, mirror_addr(AddrCrtData), 8'($urandom));
      end
      4, 5: begin
        send_access(ACT_WRITE, mirror_addr(AddrDmaMode), CmdDmaMode);
        send_access(ACT_WRITE, mirror_addr(AddrDmaBase), 8'($urandom));
        send_access(ACT_WRITE, mirror_addr(AddrDmaBase), 8'($urandom));
        send_access(ACT_WRITE, mirror_addr(AddrDmaSize), 8'($urandom));
        if ($urandom_range(0, 5) != 0)
          send_access(ACT_WRITE, mirror_addr(AddrDmaSize), 8'($urandom));
        if ($urandom_range(0, 1) != 0)
          send_access(ACT_WRITE, mirror_addr(AddrDmaMode), CmdDmaStart);
      end
      6: send_access(ACT_WRITE, mirror_addr(AddrDmaMode), CmdDmaStart);
      7: send_access(ACT_WRITE, mirror_addr(AddrIndicator), 8'($urandom));
      8: begin
        case ($urandom_range(0, 3))
          0: reg_data = CmdCursor;
          1: reg_data = CmdDmaStart;
          2: reg_data = CmdFormat;
          default: reg_data = 8'($urandom);
        endcase
        send_access(action_e'($urandom_range(0, 3)),
                    mirror_addr(RegAddrs[$urandom_range(0, 6)]), reg_data);
      end
      default: send_access(action_e'($urandom_range(0, 3)), pick_addr(), 8'($urandom));
    endcase
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    stop_at = sent + count;
    while (sent < stop_at) random_sequence();
  endtask

  initial begin
    sb           = new;
    idle_pct     = 0;
    sent         = 0;
    rst_ni       <= 1'b0;
    start_i      <= 1'b0;
    action_i     <= ACT_READ;
    address_i    <= '0;
    write_data_i <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    run_random(RandomItems / 4);
    idle_pct = 67;
    run_random(RandomItems / 4);
    // sender holds off until every transfer has its result back
    drain_results();
    idle_pct = 0;
    run_random(RandomItems / 4);
    idle_pct = 31;
    run_random(RandomItems / 4);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("memory_map_video_setup_capture: match");
    end else begin
      $display("memory_map_video_setup_capture: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mvsc_pkg.sv
rtl/mvsc_decode.sv
rtl/memory_map_video_setup_capture.sv
dv/memory_map_video_setup_capture_test.sv
